@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the reciprocal square root unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a signal holds its value in the cycle after a condition.
`define FIM_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ rtl/core/fim_pkg.sv @@
// Types and constants of the reciprocal square root unit.
package fim_pkg;

	localparam logic [31:0] RSQRT_MAGIC  = 32'h5f3759df;
	localparam logic [31:0] FP_HALF      = 32'h3f000000;
	localparam logic [31:0] FP_THREE_HLF = 32'h3fc00000;
	localparam logic [31:0] CANON_NAN    = 32'h7fc00000;

	// Number of register stages in each floating-point unit
	localparam int unsigned FP_STAGES = 3;

	typedef enum logic [1:0] {
		SPEC_NONE,
		SPEC_ZERO,
		SPEC_INF,
		SPEC_NAN
	} fim_spec_t;

endpackage

@@ rtl/core/fast_inverse_square_root_unit.sv @@
// Pipelined reciprocal square root: bit-trick estimate refined by one Newton step.
// The unit takes one IEEE-754 binary32 pattern per item and returns the classic
// 0x5f3759df approximation of 1/sqrt(x), with every float operation rounded to
// nearest even and subnormals handled in full; any NaN result leaves as the
// canonical quiet NaN 0x7fc00000. It accepts a new item in every cycle. Each item
// passes through five floating-point units of three stages each (0.5*x, half*y,
// t*y, 1.5-t, y*u) in series, and then through the output register. The
// whole pipeline advances together; it stalls only while a result waits at the
// output and the downstream side is not ready, so an item may enter in the very
// cycle the waiting result is taken.
module fast_inverse_square_root_unit import fim_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] result_bits
);

`include "assert_macros.svh"

	localparam int unsigned DEPTH = 5 * FP_STAGES + 1;
	localparam int unsigned YDLY  = 4 * FP_STAGES;

	logic             adv;
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      est;
	logic [31:0]      y_q [YDLY];
	logic [31:0]      half, t1, t2, u, r;
	logic [31:0]      out_s16;

	// Advance the whole pipeline unless a result is held at the output
	assign adv      = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[DEPTH-1];
	assign m_tdata  = out_s16;

	// Estimate word: magic minus the operand shifted right arithmetically
	assign est = RSQRT_MAGIC - {s_tdata[31], s_tdata[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Hold the estimate alongside the units that need it
	always_ff @(posedge clk) begin
		if (adv) begin
			y_q[0] <= est;
			for (int i = 1; i < YDLY; i++)
				y_q[i] <= y_q[i-1];
		end
	end

	fim_fmul u_half (.clk(clk), .en(adv), .a(s_tdata), .b(FP_HALF), .r(half));
	fim_fmul u_t1   (.clk(clk), .en(adv), .a(half), .b(y_q[FP_STAGES-1]), .r(t1));
	fim_fmul u_t2   (.clk(clk), .en(adv), .a(t1), .b(y_q[2*FP_STAGES-1]), .r(t2));
	fim_fadd u_u    (.clk(clk), .en(adv), .a(FP_THREE_HLF), .b({~t2[31], t2[30:0]}), .r(u));
	fim_fmul u_r    (.clk(clk), .en(adv), .a(y_q[YDLY-1]), .b(u), .r(r));

	// Output register: drop NaN payloads in favour of the canonical quiet NaN
	always_ff @(posedge clk) begin
		if (adv) begin
			if ((&r[30:23]) && (|r[22:0]))
				out_s16 <= CANON_NAN;
			else
				out_s16 <= r;
		end
	end

	`FIM_ASSERT_HOLD(a_stall_holds_valids, !s_tready, vld_q, "valid line moved during stall")
	`FIM_ASSERT(a_nan_canonical, m_tvalid && (&m_tdata[30:23]) && (|m_tdata[22:0]) |-> m_tdata == CANON_NAN, "non-canonical NaN at output")
	`FIM_ASSERT(a_no_accept_when_full, s_tvalid && s_tready |-> !m_tvalid || m_tready, "item accepted while output stalled")

endmodule

@@ rtl/core/fim_fmul.sv @@
// Three-stage binary32 multiplier, round to nearest even, gradual underflow.
module fim_fmul import fim_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0]  ea, eb;
	fim_spec_t   spec0;
	logic signed [11:0] e0;

	logic [47:0] p_s1;
	logic signed [11:0] e_s1;
	logic        sgn_s1;
	fim_spec_t   spec_s1;

	logic [5:0]  lead;
	logic [47:0] pn;
	logic signed [11:0] en2;

	logic [47:0] pn_s2;
	logic signed [11:0] e_s2;
	logic        sgn_s2;
	fim_spec_t   spec_s2;

	logic        ovf;
	logic signed [11:0] rs;
	logic [5:0]  rsc;
	logic [95:0] ext;
	logic [47:0] m;
	logic        xs, g, st, up;
	logic [7:0]  ef;
	logic [30:0] rnd;
	logic [31:0] res;

	always_comb begin
		a_nan  = (&a[30:23]) && (|a[22:0]);
		b_nan  = (&b[30:23]) && (|b[22:0]);
		a_inf  = (&a[30:23]) && !(|a[22:0]);
		b_inf  = (&b[30:23]) && !(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		e0 = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
			spec0 = SPEC_NAN;
		else if (a_inf || b_inf)
			spec0 = SPEC_INF;
		else if (a_zero || b_zero)
			spec0 = SPEC_ZERO;
		else
			spec0 = SPEC_NONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= ma * mb;
			e_s1    <= e0;
			sgn_s1  <= a[31] ^ b[31];
			spec_s1 <= spec0;
		end
	end

	// Normalise: bring the leading one to bit 47
	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (p_s1[i])
				lead = 6'(i);
		end
		pn  = p_s1 << (6'd47 - lead);
		en2 = e_s1 + $signed({6'd0, lead}) - 12'sd46;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pn_s2   <= pn;
			e_s2    <= en2;
			sgn_s2  <= sgn_s1;
			spec_s2 <= spec_s1;
		end
	end

	// Denormalise if needed, then round
	always_comb begin
		ovf = (e_s2 >= 12'sd255);
		rs  = 12'sd1 - e_s2;
		rsc = (rs > 12'sd48) ? 6'd48 : rs[5:0];
		ext = {pn_s2, 48'd0} >> rsc;
		if (e_s2 > 12'sd0) begin
			m  = pn_s2;
			xs = 1'b0;
			ef = e_s2[7:0];
		end else begin
			m  = ext[95:48];
			xs = |ext[47:0];
			ef = 8'd0;
		end
		g   = m[23];
		st  = (|m[22:0]) | xs;
		up  = g & (st | m[24]);
		rnd = {ef, m[46:24]} + {30'd0, up};
		case (spec_s2)
			SPEC_NAN:  res = CANON_NAN;
			SPEC_INF:  res = {sgn_s2, 8'hff, 23'd0};
			SPEC_ZERO: res = {sgn_s2, 31'd0};
			default:   res = ovf ? {sgn_s2, 8'hff, 23'd0} : {sgn_s2, rnd};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			r <= res;
	end

endmodule

@@ rtl/core/fim_fadd.sv @@
// Three-stage binary32 adder, round to nearest even, gradual underflow.
module fim_fadd import fim_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	fim_spec_t   spec0;
	logic        sgn0;
	logic [31:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [4:0]  dc;
	logic [23:0] mbg, msm;
	logic [53:0] ext;
	logic [26:0] al;
	logic [27:0] sum;

	logic [27:0] sum_s1;
	logic [7:0]  e_s1;
	logic        sgn_s1;
	fim_spec_t   spec_s1;

	logic [4:0]  lead, sh, lim;
	logic [26:0] n;
	logic [8:0]  e2;
	fim_spec_t   spec2;
	logic        sgn2;

	logic [26:0] n_s2;
	logic [8:0]  e_s2;
	logic        sgn_s2;
	fim_spec_t   spec_s2;

	logic        ovf, g, st, up;
	logic [7:0]  ef;
	logic [30:0] rnd;
	logic [31:0] res;

	always_comb begin
		a_nan  = (&a[30:23]) && (|a[22:0]);
		b_nan  = (&b[30:23]) && (|b[22:0]);
		a_inf  = (&a[30:23]) && !(|a[22:0]);
		b_inf  = (&b[30:23]) && !(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sgn0   = a_inf ? a[31] : b[31];
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
			spec0 = SPEC_NAN;
		else if (a_inf || b_inf)
			spec0 = SPEC_INF;
		else if (a_zero && b_zero) begin
			spec0 = SPEC_ZERO;
			sgn0  = a[31] & b[31];
		end else
			spec0 = SPEC_NONE;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mbg = {|big[30:23], big[22:0]};
		msm = {|sml[30:23], sml[22:0]};
		d   = eb - es;
		dc  = (d > 8'd27) ? 5'd27 : d[4:0];
		ext = {msm, 3'd0, 27'd0} >> dc;
		al  = {ext[53:28], ext[27] | (|ext[26:0])};
		if (big[31] ^ sml[31])
			sum = {1'b0, mbg, 3'd0} - {1'b0, al};
		else
			sum = {1'b0, mbg, 3'd0} + {1'b0, al};
		if (spec0 == SPEC_NONE)
			sgn0 = big[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= sum;
			e_s1    <= eb;
			sgn_s1  <= sgn0;
			spec_s1 <= spec0;
		end
	end

	// Normalise, stopping at the smallest normal exponent
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (sum_s1[i])
				lead = 5'(i);
		end
		sh  = 5'd26 - lead;
		lim = 5'(e_s1 - 8'd1 > 8'd26 ? 8'd26 : e_s1 - 8'd1);
		if (sh > lim)
			sh = lim;
		if (sum_s1[27]) begin
			n  = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			e2 = {1'b0, e_s1} + 9'd1;
		end else begin
			n  = sum_s1[26:0] << sh;
			e2 = {1'b0, e_s1} - {4'd0, sh};
		end
		spec2 = spec_s1;
		sgn2  = sgn_s1;
		// Exact cancellation gives +0
		if (spec_s1 == SPEC_NONE && sum_s1 == 28'd0) begin
			spec2 = SPEC_ZERO;
			sgn2  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= n;
			e_s2    <= e2;
			sgn_s2  <= sgn2;
			spec_s2 <= spec2;
		end
	end

	always_comb begin
		ovf = (e_s2 >= 9'd255);
		ef  = n_s2[26] ? e_s2[7:0] : 8'd0;
		g   = n_s2[2];
		st  = |n_s2[1:0];
		up  = g & (st | n_s2[3]);
		rnd = {ef, n_s2[25:3]} + {30'd0, up};
		case (spec_s2)
			SPEC_NAN:  res = CANON_NAN;
			SPEC_INF:  res = {sgn_s2, 8'hff, 23'd0};
			SPEC_ZERO: res = {sgn_s2, 31'd0};
			default:   res = ovf ? {sgn_s2, 8'hff, 23'd0} : {sgn_s2, rnd};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			r <= res;
	end

endmodule
